// ===== rtl/ptdt_pkg.sv =====
// Shared types and character constants for the padded decimal text block.
package ptdt_pkg;

  localparam int unsigned BIN_W      = 32;
  localparam int unsigned DIGITS_MAX = 10;
  localparam int unsigned CNT_W      = $clog2(BIN_W);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [3:0] DIGITS_MAX_W = 4'd10;

  // control shared by every digit cell of the chain
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/ptdt_bcd_cell.sv =====
// One BCD digit cell of the shift-and-add-3 conversion chain.
module ptdt_bcd_cell (
  input  logic                  clk,
  input  ptdt_pkg::cell_ctrl_t  ctrl,
  input  logic                  din,
  output logic                  dout,
  output logic [3:0]            digit
);
  import ptdt_pkg::*;

  logic [3:0] adj;

  // correct before the doubling so the digit never passes nine
  assign adj  = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign dout = adj[3];

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      digit <= 4'd0;
    end else if (ctrl.shift) begin
      digit <= {adj[2:0], din};
    end
  end

endmodule

// ===== rtl/padded_integer_to_decimal_text.sv =====
// Top level: signed 32-bit value to padded ASCII decimal text, one character per transfer.
// Steps: conversion shifts (one per input bit) through the chain of ten BCD cells,
// then sizing the field, then each character into the output register.
// A new value is taken only once the last character of the previous one is registered;
// characters leave at one per cycle while the receiver is ready.
// Reset: rst is synchronous, active high; clears the sequencer and the output valid.
module padded_integer_to_decimal_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // value[31:0], min_width[39:32], pad_with_space[40],
                                 // dest_size[48:41], zero[55:49]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // character[7:0]
  output logic        m_tlast,
  output logic        m_tuser    // status[0]
);
  import ptdt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PREP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [BIN_W-1:0] sh;
  logic             neg;
  logic             sign_pending;
  logic [7:0]       min_width;
  logic             pad_space;
  logic [7:0]       dest_size;
  logic [3:0]       ndig;
  logic [3:0]       pos;
  logic             err;

  cell_ctrl_t       ctrl;
  logic [3:0]       digit [DIGITS_MAX];
  logic             carry [DIGITS_MAX+1];

  logic [BIN_W-1:0] in_value;
  logic [BIN_W-1:0] in_mag;
  logic             accept;
  logic             out_free;
  logic             emit;

  logic [3:0]       ndig_next;
  logic [3:0]       width_next;
  logic [3:0]       len_next;
  logic [3:0]       dsel;
  logic [7:0]       char_next;
  logic             last_next;

  assign in_value = s_tdata[31:0];
  assign in_mag   = in_value[BIN_W-1] ? (~in_value + 1'b1) : in_value;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == ST_EMIT) && out_free;

  assign ctrl = cell_ctrl_t'{clr: accept, shift: (state == ST_CONV)};

  assign carry[0] = sh[BIN_W-1];

  for (genvar g = 0; g < DIGITS_MAX; g++) begin : g_cell
    ptdt_bcd_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .din   (carry[g]),
      .dout  (carry[g+1]),
      .digit (digit[g])
    );
  end

  // digit count and field width, taken from the finished BCD digits
  always_comb begin
    ndig_next = 4'd1;
    for (int i = 1; i < DIGITS_MAX; i++) begin
      if (digit[i] != 4'd0) begin
        ndig_next = 4'(i + 1);
      end
    end
    if (min_width < {4'd0, ndig_next}) begin
      width_next = ndig_next;
    end else if (min_width > {4'd0, DIGITS_MAX_W}) begin
      width_next = DIGITS_MAX_W;
    end else begin
      width_next = min_width[3:0];
    end
    len_next = width_next + {3'd0, neg};
  end

  always_comb begin
    dsel      = digit[pos - 4'd1];
    last_next = !sign_pending && (pos == 4'd1);
    if (sign_pending) begin
      char_next = CHAR_MINUS;
    end else if (pos > ndig) begin
      char_next = pad_space ? CHAR_SPACE : CHAR_ZERO;
    end else begin
      char_next = CHAR_ZERO + {4'd0, dsel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            sh        <= in_mag;
            neg       <= in_value[BIN_W-1];
            min_width <= s_tdata[39:32];
            pad_space <= s_tdata[40];
            dest_size <= s_tdata[48:41];
            cnt       <= '0;
            state     <= ST_CONV;
          end
        end
        ST_CONV: begin
          sh  <= {sh[BIN_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(BIN_W - 1)) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          ndig         <= ndig_next;
          pos          <= width_next;
          sign_pending <= neg;
          err          <= (dest_size <= {4'd0, len_next});
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (err) begin
              m_tdata <= CHAR_NUL;
              m_tlast <= 1'b1;
              m_tuser <= 1'b1;
              state   <= ST_IDLE;
            end else begin
              m_tdata <= char_next;
              m_tlast <= last_next;
              m_tuser <= 1'b0;
              if (sign_pending) begin
                sign_pending <= 1'b0;
              end else begin
                pos <= pos - 4'd1;
              end
              if (last_next) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again straight after a transfer");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == CHAR_NUL)))
    else $error("error result not a lone NUL with last");

  a_no_emit_while_conv: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |=> !$rose(m_tvalid))
    else $error("character produced during conversion");
`endif

endmodule

// ===== tb/sv/padded_integer_to_decimal_text_tb.sv =====
// Self-checking testbench for padded_integer_to_decimal_text: directed table then random values.
`timescale 1ns / 100ps

module padded_integer_to_decimal_text_tb;
  import ptdt_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_ITEMS = 196;
  localparam int unsigned CALM_ITEMS   = 40;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 48;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_MAX    = 40;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_TEXT,
    CHK_OVERFLOW
  } check_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       status;
  } text_char_t;

  typedef struct {
    logic [31:0] value;
    logic [7:0]  width_req;
    logic        pad_space;
    logic [7:0]  size;
    check_kind_t kind;
    string       text;
  } stim_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  text_char_t  pending_chars [$];
  int unsigned stall_pct     = 25;
  bit          hold_rx       = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned chars_checked = 0;
  int unsigned overflows     = 0;
  int unsigned held_cycles   = 0;

  // extremes, pad choices, width clamping and overflow edges
  stim_row_t directed_rows [$] = '{
    '{32'd0,          8'd0,   1'b0, 8'd2,   CHK_TEXT,     "0"},
    '{32'd0,          8'd0,   1'b1, 8'd1,   CHK_OVERFLOW, ""},
    '{32'd0,          8'd255, 1'b0, 8'd0,   CHK_OVERFLOW, ""},
    '{32'h7FFFFFFF,   8'd0,   1'b0, 8'd11,  CHK_TEXT,     "2147483647"},
    '{32'h7FFFFFFF,   8'd255, 1'b1, 8'd255, CHK_TEXT,     "2147483647"},
    '{32'h7FFFFFFF,   8'd10,  1'b0, 8'd10,  CHK_OVERFLOW, ""},
    '{32'h80000000,   8'd0,   1'b0, 8'd12,  CHK_TEXT,     "-2147483648"},
    '{32'h80000000,   8'd0,   1'b0, 8'd11,  CHK_OVERFLOW, ""},
    '{32'h80000000,   8'd255, 1'b1, 8'd255, CHK_TEXT,     "-2147483648"},
    '{32'hFFFFFFFF,   8'd0,   1'b0, 8'd3,   CHK_TEXT,     "-1"},
    '{32'hFFFFFFFF,   8'd5,   1'b0, 8'd7,   CHK_TEXT,     "-00001"},
    '{32'hFFFFFFFF,   8'd5,   1'b1, 8'd7,   CHK_TEXT,     "-    1"},
    '{32'hFFFFFFFF,   8'd5,   1'b1, 8'd6,   CHK_OVERFLOW, ""},
    '{32'd42,         8'd255, 1'b1, 8'd255, CHK_TEXT,     "        42"},
    '{32'd42,         8'd255, 1'b0, 8'd11,  CHK_TEXT,     "0000000042"},
    '{32'd12345,      8'd2,   1'b0, 8'd6,   CHK_TEXT,     "12345"},
    '{32'd12345,      8'd2,   1'b0, 8'd5,   CHK_OVERFLOW, ""},
    '{32'h80000001,   8'd10,  1'b1, 8'd12,  CHK_MODEL,    ""},
    '{32'd999999999,  8'd10,  1'b0, 8'd11,  CHK_MODEL,    ""},
    '{32'd1000000000, 8'd0,   1'b0, 8'd11,  CHK_MODEL,    ""},
    '{32'd7,          8'd3,   1'b1, 8'd4,   CHK_MODEL,    ""},
    '{32'h5A5A5A5A,   8'd8,   1'b1, 8'd200, CHK_MODEL,    ""},
    '{32'hA5A5A5A5,   8'd4,   1'b0, 8'd128, CHK_MODEL,    ""},
    '{32'hFFFF0000,   8'd12,  1'b1, 8'd13,  CHK_MODEL,    ""}
  };

  padded_integer_to_decimal_text u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // Sign, pad and digits, without the size check. The most negative value negates to
  // itself, which read unsigned is its own magnitude, so it needs no path of its own.
  function automatic void render_text(input logic [31:0] value, input logic [7:0] width_req,
                                      input logic pad_space, output logic [7:0] txt [$]);
    logic [31:0] mag;
    logic [3:0]  dig [10];
    int          ndig;
    int          width;
    txt  = {};
    mag  = value[31] ? -value : value;
    ndig = 1;
    for (int k = 0; k < 10; k++) begin
      dig[k] = 4'(mag % 10);
      mag    = mag / 10;
      if (dig[k] != 4'd0) ndig = k + 1;
    end
    width = (int'(width_req) < ndig) ? ndig : int'(width_req);
    if (width > DIGITS_MAX) width = DIGITS_MAX;
    if (value[31]) txt.push_back(CHAR_MINUS);
    for (int k = width - 1; k >= 0; k--) begin
      if (k >= ndig) txt.push_back(pad_space ? CHAR_SPACE : CHAR_ZERO);
      else txt.push_back(CHAR_ZERO + 8'(dig[k]));
    end
  endfunction

  function automatic void predict_chars(input logic [31:0] value, input logic [7:0] width_req,
                                        input logic pad_space, input logic [7:0] size);
    logic [7:0] txt [$];
    render_text(value, width_req, pad_space, txt);
    if (int'(size) < txt.size() + 1) begin
      pending_chars.push_back('{ch: CHAR_NUL, last: 1'b1, status: 1'b1});
    end else begin
      foreach (txt[k])
        pending_chars.push_back('{ch: txt[k], last: (k == txt.size() - 1), status: 1'b0});
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_MAX) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic send_value(input logic [31:0] value, input logic [7:0] width_req,
                            input logic pad_space, input logic [7:0] size);
    if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, size, pad_space, width_req, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // sender: directed table, then random values
  initial begin
    logic [31:0] value;
    logic [7:0]  width_req;
    logic        pad_space;
    logic [7:0]  size;
    logic [7:0]  txt [$];
    int unsigned pick;
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    int unsigned len;

    while (rst) @(posedge clk);

    foreach (directed_rows[r]) begin
      send_value(directed_rows[r].value, directed_rows[r].width_req,
                 directed_rows[r].pad_space, directed_rows[r].size);
      case (directed_rows[r].kind)
        CHK_TEXT:
          for (int k = 0; k < directed_rows[r].text.len(); k++)
            pending_chars.push_back('{ch: directed_rows[r].text[k],
                                      last: (k == directed_rows[r].text.len() - 1),
                                      status: 1'b0});
        CHK_OVERFLOW:
          pending_chars.push_back('{ch: CHAR_NUL, last: 1'b1, status: 1'b1});
        default:
          predict_chars(directed_rows[r].value, directed_rows[r].width_req,
                        directed_rows[r].pad_space, directed_rows[r].size);
      endcase
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        stall_pct = 0;
      end else if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 50;
        endcase
      end
      // receiver stalls for a long stretch while values keep coming
      if (n == 50) hold_rx = 1'b1;
      // let the output drain completely once
      if (n == 130) begin
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
      end

      // mostly values of a chosen digit count, some raw words, a few most-negative
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        value = 32'h80000000;
      end else if (pick <= 2) begin
        value = $urandom;
      end else begin
        ndig = $urandom_range(1, 10);
        lo   = 1;
        for (int k = 1; k < ndig; k++) lo = lo * 10;
        hi   = (ndig == 10) ? 32'h7FFFFFFF : lo * 10 - 1;
        if (ndig == 1) lo = 0;
        value = $urandom_range(hi, lo);
        if ($urandom_range(0, 1)) value = -value;
      end
      width_req = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 12));
      pad_space = 1'($urandom_range(0, 1));

      // size mostly fits, with the boundary on both sides and some raw bytes
      render_text(value, width_req, pad_space, txt);
      len = txt.size();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: size = 8'($urandom_range(len + 1, len + 4));
        6:                size = 8'(len + 1);
        7:                size = 8'(len);
        8:                size = 8'($urandom_range(0, len));
        default:          size = 8'($urandom_range(0, 255));
      endcase

      send_value(value, width_req, pad_space, size);
      predict_chars(value, width_req, pad_space, size);
    end
    s_tvalid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d values (%0d from the table); checked %0d characters, %0d overflow transfers",
             items_sent, directed_rows.size(), chars_checked, overflows);
    $display("Receiver hold-off of %0d cycles, idle bursts on both sides, %0d mismatches",
             held_cycles, mismatches);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // receiver: random idle bursts plus the one long hold-off
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        m_tready <= 1'b0;
        for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++) @(posedge clk);
        hold_rx = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer char=%02h last=%b status=%b",
                                  m_tdata, m_tlast, m_tuser));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (want.status) overflows++;
        if (m_tdata !== want.ch)
          report_mismatch($sformatf("char %02h, wanted %02h", m_tdata, want.ch));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last %b, wanted %b", m_tlast, want.last));
        if (m_tuser !== want.status)
          report_mismatch($sformatf("status %b, wanted %b", m_tuser, want.status));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d characters outstanding",
             cycle_count, pending_chars.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
